// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_SYNC_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/swrl_pkg.sv =====
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared widths, codes and types of the sliding window rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // BUCKETS must be a power of two (16 .. 65536): the bucket index is the
  // low bits of the timestamp.
  localparam int BUCKETS_DEF = 1024;

  localparam int TIME_W  = 32;
  localparam int WIN_W   = 10;
  localparam int MAX_W   = 16;
  localparam int CNT_W   = 16;
  localparam int EPOCH_W = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] WINDOW_MS_RST = WIN_W'(1000);
  localparam logic [MAX_W-1:0] MAX_COUNT_RST = MAX_W'(100);

  // request queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MS = 1'b0,
    CFG_MAX_COUNT = 1'b1
  } cfg_idx_t;

  localparam logic STATUS_ADMIT  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [WIN_W-1:0]  win;     // window length, clamped to BUCKETS-1
  } req_t;

endpackage

// ===== hdl/swrl_front.sv =====
// ----------------------------------------------------------------------------
// swrl_front
// Accepts requests, clamps the window length and queues them for the back end.
// ----------------------------------------------------------------------------
module swrl_front #(
  parameter int BUCKETS = swrl_pkg::BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [swrl_pkg::TIME_W-1:0] in_now_ms,
  input  logic [swrl_pkg::WIN_W-1:0]  window_ms,
  output logic                       q_valid,
  input  logic                       q_ready,
  output swrl_pkg::req_t             q_item
);
  import swrl_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  req_t               ent_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  fill_r, fill_nxt;
  logic               push, pop;
  logic               win_clip;
  req_t               req_in;

  // a window of BUCKETS or more acts as BUCKETS-1
  assign win_clip = {{(TIME_W-WIN_W){1'b0}}, window_ms} > TIME_W'(BUCKETS - 1);
  assign req_in.now_ms = in_now_ms;
  assign req_in.win    = win_clip ? WIN_W'(BUCKETS - 1) : window_ms;

  assign in_ready = (fill_r != CNT_QW'(QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

// ===== hdl/swrl_back.sv =====
// ----------------------------------------------------------------------------
// swrl_back
// Bucket memory, expiry walk, admit decision and the result register.
// ----------------------------------------------------------------------------
module swrl_back #(
  parameter int BUCKETS = swrl_pkg::BUCKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  swrl_pkg::req_t              q_item,
  input  logic [swrl_pkg::MAX_W-1:0]  max_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [swrl_pkg::CNT_W-1:0]  out_window_count
);
  import swrl_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int NW = IW + 1;

  // a bucket only counts when its tag matches the current epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]   cnt;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_WALK,
    S_RD_IDX,
    S_ADMIT,
    S_OPEN
  } state_t;

  entry_t mem [BUCKETS];
  entry_t rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  state_t             state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [IW-1:0]      sweep_r, sweep_nxt;
  logic               open_pend_r, open_pend_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [IW-1:0]      j_r, j_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [IW-1:0]      oldest_r, oldest_nxt;
  logic [TIME_W-1:0]  newest_r, newest_nxt;
  logic               open_r, open_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic [IW-1:0]      idx;
  logic [IW-1:0]      q_idx;
  logic [CNT_W-1:0]   rd_cnt;
  logic               expired;
  logic               walk_hit, walk_clr, walk_adv, walk_cont;
  logic [CNT_W-1:0]   walk_total;
  logic [IW-1:0]      walk_j;
  logic [IW-1:0]      j_inc;
  logic [NW-1:0]      n_inc;
  logic [TIME_W-1:0]  q_delta;
  logic               q_open;
  logic               out_free;

  assign idx    = now_r[IW-1:0];
  assign q_idx  = q_item.now_ms[IW-1:0];
  assign rd_cnt = (rd_data_r.tag == epoch_r) ? rd_data_r.cnt : '0;
  assign expired = (now_r - rd_data_r.stamp) >= {{(TIME_W-WIN_W){1'b0}}, win_r};

  assign j_inc      = j_r + 1'b1;
  assign n_inc      = n_r + 1'b1;
  assign walk_hit   = (rd_cnt != '0);
  assign walk_clr   = walk_hit && expired;
  assign walk_adv   = !walk_hit || walk_clr;
  assign walk_total = walk_clr ? (total_r - rd_cnt) : total_r;
  assign walk_j     = walk_adv ? j_inc : j_r;
  assign walk_cont  = walk_adv && (n_inc < NW'(BUCKETS)) && (walk_total != '0);

  // a new window opens on first use, on time going back or after a gap
  assign q_delta = q_item.now_ms - newest_r;
  assign q_open  = !open_r || (q_item.now_ms < newest_r) ||
                   (q_delta > {{(TIME_W-WIN_W){1'b0}}, q_item.win});

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    sweep_nxt      = sweep_r;
    open_pend_nxt  = open_pend_r;
    now_nxt        = now_r;
    win_nxt        = win_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    total_nxt      = total_r;
    oldest_nxt     = oldest_r;
    newest_nxt     = newest_r;
    open_nxt       = open_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    q_ready        = 1'b0;
    rd_addr        = j_r;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = '0;

    case (state_r)
      S_SWEEP: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == IW'(BUCKETS - 1)) begin
          epoch_nxt     = '0;
          open_pend_nxt = 1'b0;
          state_nxt     = open_pend_r ? S_OPEN : S_IDLE;
        end
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          now_nxt = q_item.now_ms;
          win_nxt = q_item.win;
          if (q_open) begin
            if (epoch_r == '1) begin
              // tags are about to wrap: wipe the memory first
              sweep_nxt     = '0;
              open_pend_nxt = 1'b1;
              state_nxt     = S_SWEEP;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
              state_nxt = S_OPEN;
            end
          end else if (total_r == '0) begin
            oldest_nxt = q_idx;
            state_nxt  = S_RD_IDX;
          end else begin
            j_nxt     = oldest_r;
            n_nxt     = '0;
            rd_addr   = oldest_r;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // one bucket per cycle; next read goes out while this one is judged
        if (walk_clr) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = '{tag: epoch_r, cnt: '0, stamp: rd_data_r.stamp};
        end
        total_nxt = walk_total;
        j_nxt     = walk_j;
        n_nxt     = n_inc;
        rd_addr   = j_inc;
        if (!walk_cont) begin
          oldest_nxt = (walk_total == '0) ? idx : walk_j;
          state_nxt  = S_RD_IDX;
        end
      end
      S_RD_IDX: begin
        rd_addr   = idx;
        state_nxt = S_ADMIT;
      end
      S_ADMIT: begin
        // keep the request's bucket on the read port while the result stalls
        rd_addr = idx;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (total_r >= max_count) begin
            out_status_nxt = STATUS_REJECT;
            out_count_nxt  = total_r;
          end else begin
            wr_en          = 1'b1;
            wr_data        = '{tag: epoch_r, cnt: rd_cnt + CNT_W'(1), stamp: now_r};
            total_nxt      = total_r + CNT_W'(1);
            newest_nxt     = now_r;
            out_status_nxt = STATUS_ADMIT;
            out_count_nxt  = total_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_OPEN: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_data        = '{tag: epoch_r, cnt: CNT_W'(1), stamp: now_r};
          total_nxt      = CNT_W'(1);
          oldest_nxt     = idx;
          newest_nxt     = now_r;
          open_nxt       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_ADMIT;
          out_count_nxt  = CNT_W'(1);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      epoch_r     <= '0;
      sweep_r     <= '0;
      open_pend_r <= 1'b0;
      total_r     <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      sweep_r      <= sweep_nxt;
      open_pend_r  <= open_pend_nxt;
      now_r        <= now_nxt;
      win_r        <= win_nxt;
      j_r          <= j_nxt;
      n_r          <= n_nxt;
      total_r      <= total_nxt;
      oldest_r     <= oldest_nxt;
      newest_r     <= newest_nxt;
      open_r       <= open_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_window_count = out_count_r;

endmodule

// ===== hdl/sliding_window_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_core
// Per-millisecond bucket rate limiter with a sliding window of window_ms.
// ----------------------------------------------------------------------------
// Each request (in_now_ms) yields one result: out_status 0 admitted, 1 rejected,
// and out_window_count, the requests counted in the window after this request.
// A two-entry queue takes requests while the engine works. A request that opens
// a new window goes from S_IDLE to S_OPEN; any other goes through S_RD_IDX and
// S_ADMIT, after an expiry walk in S_WALK if the window is not empty. The walk
// steps one bucket per cycle over separate memory read and write ports, at most
// BUCKETS, amortized since each bucket is cleared at most once per window. After
// reset, and on every 256th window opening ahead of the request, the engine
// sweeps all BUCKETS buckets (1024 by default). BUCKETS must be a power of two.
// Configuration: cfg_index 0 is window_ms (low 10 bits), 1 is max_count.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_core #(
  parameter int BUCKETS = swrl_pkg::BUCKETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swrl_pkg::TIME_W-1:0]      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic [swrl_pkg::CNT_W-1:0]       out_window_count,
  input  logic                             cfg_wr_en,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import swrl_pkg::*;

  logic [WIN_W-1:0] window_ms_r, window_ms_nxt;
  logic [MAX_W-1:0] max_count_r, max_count_nxt;
  logic             q_valid;
  logic             q_ready;
  req_t             q_item;

  always_comb begin
    window_ms_nxt = window_ms_r;
    max_count_nxt = max_count_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WINDOW_MS: window_ms_nxt = cfg_wdata[WIN_W-1:0];
        CFG_MAX_COUNT: max_count_nxt = cfg_wdata[MAX_W-1:0];
        default: begin
          window_ms_nxt = window_ms_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= WINDOW_MS_RST;
      max_count_r <= MAX_COUNT_RST;
    end else begin
      window_ms_r <= window_ms_nxt;
      max_count_r <= max_count_nxt;
    end
  end

  swrl_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_now_ms (in_now_ms),
    .window_ms (window_ms_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  swrl_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item),
    .max_count        (max_count_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_window_count (out_window_count)
  );

endmodule

// ===== hdl/swrl_checker.sv =====
// ----------------------------------------------------------------------------
// swrl_checker
// Port-level assertions for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swrl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_status,
  input logic [swrl_pkg::CNT_W-1:0]  out_window_count
);
  import swrl_pkg::*;

  // a stalled result transaction holds
  `ASSERT_SYNC(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_window_count), "result changed while stalled")

  // an admitted request is always in the window count
  `ASSERT_SYNC(a_admit_counted, clk, rst_n, out_valid && (out_status == STATUS_ADMIT) |-> (out_window_count != '0), "admitted with empty window")

  // reset empties the queue and the result register
  `ASSERT_SYNC_NORST(a_reset_clear, clk, !rst_n |=> !out_valid && in_ready, "reset left state behind")

  // a stalled input transaction stays offered
  `ASSERT_SYNC(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid, "input transaction withdrawn while stalled")

endmodule

bind sliding_window_rate_limiter_core swrl_checker u_swrl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_window_count (out_window_count)
);
